@@ rtl/nsr_pkg.sv @@
// Shared constants and types for the Newton square root block.
package nsr_pkg;

  // Default operand format: signed Q16.16 in 32 bits
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Register widths and reset values
  localparam int EPS_W   = 16;
  localparam int ITER_W  = 10;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [EPS_W-1:0]  EPS_RESET  = EPS_W'(1);
  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(1000);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = CFG_IDX_W'(1);

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

@@ rtl/nsr_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
module nsr_div
  import nsr_pkg::*;
#(
  parameter int NUM_W = DATA_WIDTH_DEF - 1 + FRAC_BITS_DEF,
  parameter int DEN_W = DATA_WIDTH_DEF - 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output div_status_t      status
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] trial_sub;
  logic           fits;

  // Trial subtraction of the shifted partial remainder
  assign trial     = {rem_r, quo_r[NUM_W-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign fits      = (trial >= {1'b0, den_r});

  // Control: bit counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !go && busy_r && (cnt_r == CNT_W'(1));
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath: dividend bits shift out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  assign quo         = quo_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

`ifndef SYNTHESIS
  // A new division is never started over a running one
  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n) go |-> !busy_r)
    else $error("divider started while busy");
  // Done follows the last bit and never overlaps busy
  a_done_excl: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while busy");
  // A running division always has bits left to do
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> cnt_r != '0)
    else $error("divider busy with no bits left");
`endif

endmodule

@@ rtl/newton_square_root_top.sv @@
// Newton-Raphson fixed-point square root, top level.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  in_     | input     | in_valid/in_stall  | in_value
//  out_    | output    | out_valid/out_stall| out_root, out_iterations_used,
//          |           |                    | out_domain_error
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item at a time: in_stall is high from acceptance until the result has
// moved to the output register. Each Newton step runs one division on the
// bit-serial divider; a negative operand skips the divider and goes straight
// to the output register.
// The output register lets the next item be accepted while a result waits.
// Synchronous active-low reset; epsilon resets to 1, step limit to 1000.
module newton_square_root_top
  import nsr_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // operand channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [DATA_WIDTH-2:0]        out_root,
  output logic [ITER_W-1:0]            out_iterations_used,
  output logic                         out_domain_error,
  // register writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int RW    = DATA_WIDTH - 1;
  localparam int NUM_W = RW + FRAC_BITS;
  localparam int CW    = (RW > EPS_W) ? RW : EPS_W;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_CHK  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]        state_r;
  logic              go_r;
  logic [NUM_W-1:0]  scaled_r;
  logic [RW-1:0]     est_r;
  logic [RW-1:0]     next_r;
  logic [ITER_W-1:0] count_r;
  logic              err_r;
  logic [EPS_W-1:0]  eps_r;
  logic [ITER_W-1:0] maxit_r;

  logic              out_valid_r;
  logic [RW-1:0]     out_root_r;
  logic [ITER_W-1:0] out_iter_r;
  logic              out_err_r;

  logic [NUM_W-1:0]  quo;
  div_status_t       div_st;

  logic              accept;
  logic              out_free;
  logic [NUM_W:0]    sum;
  logic [NUM_W-1:0]  half;
  logic [RW-1:0]     step_est;
  logic [RW-1:0]     diff;
  logic              going;

  nsr_div #(
    .NUM_W (NUM_W),
    .DEN_W (RW)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go_r),
    .num    (scaled_r),
    .den    (est_r),
    .quo    (quo),
    .status (div_st)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // New estimate: (est + quotient) / 2, saturated to the root range
  assign sum      = (NUM_W + 1)'(est_r) + (NUM_W + 1)'(quo);
  assign half     = sum[NUM_W:1];
  assign step_est = (|half[NUM_W-1:RW]) ? {RW{1'b1}} : half[RW-1:0];

  // Convergence test on the change of the estimate and on the step limit
  assign diff  = (next_r >= est_r) ? (next_r - est_r) : (est_r - next_r);
  assign going = (count_r < maxit_r) && (CW'(diff) >= CW'(eps_r));

  // Sequencer and register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      eps_r       <= EPS_RESET;
      maxit_r     <= ITER_RESET;
    end else begin
      // divider start on a fresh operand or another step
      go_r <= ((state_r == S_IDLE) && accept && !in_value[DATA_WIDTH-1]) ||
              ((state_r == S_CHK) && (next_r != '0) && going);
      if (out_valid_r && !out_stall && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_EPSILON) begin
          eps_r <= cfg_data[EPS_W-1:0];
        end else if (cfg_index == REG_MAX_ITER) begin
          maxit_r <= cfg_data[ITER_W-1:0];
        end
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_value[DATA_WIDTH-1]) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if ((next_r != '0) && going) begin
            state_r <= S_DIV;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Operand, estimate and result registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          scaled_r <= {in_value[RW-1:0], {FRAC_BITS{1'b0}}};
          est_r    <= RW'(1) << FRAC_BITS;
          next_r   <= '0;
          count_r  <= '0;
          err_r    <= in_value[DATA_WIDTH-1];
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          next_r  <= step_est;
          count_r <= count_r + ITER_W'(1);
        end
      end
      S_CHK: begin
        if ((next_r != '0) && going) begin
          est_r <= next_r;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_root_r <= next_r;
          out_iter_r <= count_r;
          out_err_r  <= err_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_root            = out_root_r;
  assign out_iterations_used = out_iter_r;
  assign out_domain_error    = out_err_r;

`ifndef SYNTHESIS
  // The divider is never handed a zero divisor
  a_no_div_zero: assert property (@(posedge clk) disable iff (!rst_n) go_r |-> est_r != '0)
    else $error("division by zero estimate");
  // A start is only issued to an idle divider while the sequencer waits on it
  a_go_state: assert property (@(posedge clk) disable iff (!rst_n)
    go_r |-> (state_r == S_DIV) && !div_st.busy)
    else $error("divider start outside division state");
  // Domain error results carry no root and no steps
  a_dom_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_domain_error |-> (out_root == '0) && (out_iterations_used == '0))
    else $error("domain error with non-zero payload");
  // A non-negative operand always takes at least one step
  a_min_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_domain_error |-> out_iterations_used != '0)
    else $error("result without any step");
`endif

endmodule
